// ===== rtl/core/mchw_pkg.sv =====
`default_nettype none

package mchw_pkg;

  // Channel count and derived index width
  localparam int unsigned CHANNELS = 16;
  localparam int unsigned CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [31:0] DEFAULT_LIMIT = 32'd100;

  // Action codes
  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_ENABLE  = 3'd1,
    ACT_DISABLE = 3'd2,
    ACT_HB_NOW  = 3'd3,
    ACT_HB_SET  = 3'd4,
    ACT_CHECK   = 3'd5,
    ACT_REFRESH = 3'd6
  } act_e;

  // Reported channel status
  typedef enum logic [1:0] {
    STAT_ONLINE   = 2'd0,
    STAT_OFFLINE  = 2'd1,
    STAT_DISABLED = 2'd2
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN
  } state_e;

  // One channel entry in the channel RAM
  typedef struct packed {
    logic [31:0] limit;
    logic [31:0] last_hb;
  } ent_t;

  localparam int unsigned ENT_W = $bits(ent_t);

  localparam ent_t ENT_RESET = '{limit: DEFAULT_LIMIT, last_hb: 32'd0};

endpackage

`default_nettype wire

// ===== rtl/core/mchw_ram.sv =====
`default_nettype none

module mchw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/mchw_age_cmp.sv =====
`default_nettype none

module mchw_age_cmp
  import mchw_pkg::*;
(
  input  wire logic [31:0] now_i,
  input  wire ent_t        ent_i,
  output logic             offline_o
);

  logic [31:0] age;

  // Age wraps modulo 2^32; offline when strictly above the limit
  assign age       = now_i - ent_i.last_hb;
  assign offline_o = (age > ent_i.limit);

endmodule

`default_nettype wire

// ===== rtl/core/multi_channel_heartbeat_watchdog_core.sv =====
`default_nettype none

// Per-channel heartbeat watchdog. A command is taken on a clock edge with start high and
// busy low; exactly one result follows, shown for one cycle with result_valid_o, and the
// receiver cannot hold it off. Tick, disable, unused codes and commands to a channel that
// does not exist finish from idle. Enable, heartbeat, set-heartbeat and check pass through
// the access state: one read of the channel RAM, then compare and write-back. Refresh-all
// walks the channel RAM one entry per cycle through the single age comparator in the scan
// state. The result strobe is registered from the final step, and busy is already low
// then. Threshold and heartbeat time live in the channel RAM; a per-entry written bit makes
// unwritten entries read as their reset values, so no clearing pass is needed after reset.
module multi_channel_heartbeat_watchdog_core
  import mchw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  action_i,
  input  wire logic [3:0]  device_i,
  input  wire logic [31:0] value_i,
  output logic             result_valid_o,
  output logic [3:0]       device_echo_o,
  output logic [1:0]       status_o,
  output logic [15:0]      offline_map_o
);

  state_e               state_q, state_d;
  act_e                 act_q, act_d;
  logic [3:0]           dev_q, dev_d;
  logic [31:0]          val_q, val_d;
  logic [31:0]          time_q, time_d;
  logic [CHANNELS-1:0]  en_q, en_d;
  logic [CHANNELS-1:0]  off_q, off_d;
  logic [CHANNELS-1:0]  wv_q, wv_d;
  logic [CH_W-1:0]      scan_q, scan_d;

  logic                 res_vld_q;
  logic [3:0]           res_dev_q;
  status_e              res_stat_q, res_stat_d;
  logic [15:0]          res_map_q;

  logic                 ram_re, ram_we;
  logic [CH_W-1:0]      ram_raddr, ram_waddr;
  ent_t                 ram_wdata, ram_rdata;

  logic [CH_W-1:0]      in_idx, dev_idx, ent_idx, fin_idx;
  logic                 in_ok, fin_ok, fin;
  logic [3:0]           fin_dev;
  ent_t                 ent;
  logic                 eval_off;

  assign in_idx  = CH_W'(device_i);
  assign in_ok   = (32'(device_i) < 32'(CHANNELS));
  assign dev_idx = CH_W'(dev_q);

  // Channel RAM: limit and last heartbeat per channel
  mchw_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Entry under work; never-written entries read as reset values
  assign ent_idx = (state_q == ST_SCAN) ? scan_q : dev_idx;
  assign ent     = wv_q[ent_idx] ? ram_rdata : ENT_RESET;

  mchw_age_cmp u_age_cmp (
    .now_i     (time_q),
    .ent_i     (ent),
    .offline_o (eval_off)
  );

  assign ram_waddr = dev_idx;

  // Next state and datapath control
  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    dev_d     = dev_q;
    val_d     = val_q;
    time_d    = time_q;
    en_d      = en_q;
    off_d     = off_q;
    wv_d      = wv_q;
    scan_d    = scan_q;
    ram_re    = 1'b0;
    ram_raddr = in_idx;
    ram_we    = 1'b0;
    ram_wdata = ent;
    fin       = 1'b0;
    fin_dev   = dev_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          act_d   = act_e'(action_i);
          dev_d   = device_i;
          val_d   = value_i;
          fin_dev = device_i;
          unique case (act_e'(action_i))
            ACT_TICK: begin
              time_d = time_q + 32'd1;
              fin    = 1'b1;
            end
            ACT_DISABLE: begin
              if (in_ok) begin
                en_d[in_idx] = 1'b0;
              end
              fin = 1'b1;
            end
            ACT_ENABLE, ACT_HB_NOW, ACT_HB_SET, ACT_CHECK: begin
              if (in_ok) begin
                ram_re  = 1'b1;
                state_d = ST_ACCESS;
              end else begin
                fin = 1'b1;
              end
            end
            ACT_REFRESH: begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              scan_d    = '0;
              state_d   = ST_SCAN;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      // Read data is back: modify and write the entry, or evaluate it for a check
      ST_ACCESS: begin
        unique case (act_q)
          ACT_ENABLE: begin
            en_d[dev_idx]   = 1'b1;
            wv_d[dev_idx]   = 1'b1;
            ram_we          = 1'b1;
            ram_wdata.limit = val_q;
          end
          ACT_HB_NOW: begin
            wv_d[dev_idx]     = 1'b1;
            ram_we            = 1'b1;
            ram_wdata.last_hb = time_q;
          end
          ACT_HB_SET: begin
            wv_d[dev_idx]     = 1'b1;
            ram_we            = 1'b1;
            ram_wdata.last_hb = val_q;
          end
          ACT_CHECK: begin
            if (en_q[dev_idx]) begin
              off_d[dev_idx] = eval_off;
            end
          end
          default: begin
          end
        endcase
        fin     = 1'b1;
        state_d = ST_IDLE;
      end

      // Walk all channels; read of the next entry overlaps evaluation of this one
      ST_SCAN: begin
        if (en_q[scan_q]) begin
          off_d[scan_q] = eval_off;
        end
        if (scan_q == CH_W'(CHANNELS - 1)) begin
          fin     = 1'b1;
          state_d = ST_IDLE;
        end else begin
          scan_d    = scan_q + CH_W'(1);
          ram_re    = 1'b1;
          ram_raddr = scan_q + CH_W'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Status of the addressed channel after this command
  assign fin_idx = CH_W'(fin_dev);
  assign fin_ok  = (32'(fin_dev) < 32'(CHANNELS));

  always_comb begin
    if (!fin_ok) begin
      res_stat_d = STAT_DISABLED;
    end else if (!en_d[fin_idx]) begin
      res_stat_d = STAT_DISABLED;
    end else if (off_d[fin_idx]) begin
      res_stat_d = STAT_OFFLINE;
    end else begin
      res_stat_d = STAT_ONLINE;
    end
  end

  // Control and channel flag registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      time_q    <= '0;
      en_q      <= '0;
      off_q     <= '1;
      wv_q      <= '0;
      scan_q    <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      time_q    <= time_d;
      en_q      <= en_d;
      off_q     <= off_d;
      wv_q      <= wv_d;
      scan_q    <= scan_d;
      res_vld_q <= fin;
    end
  end

  // Command and result payload
  always_ff @(posedge clk_i) begin
    act_q <= act_d;
    dev_q <= dev_d;
    val_q <= val_d;
    if (fin) begin
      res_dev_q  <= fin_dev;
      res_stat_q <= res_stat_d;
      res_map_q  <= 16'(off_d);
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_vld_q;
  assign device_echo_o  = res_dev_q;
  assign status_o       = res_stat_q;
  assign offline_map_o  = res_map_q;

`ifndef SYNTHESIS
  // A channel access always ends with a result in the next cycle
  a_access_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACCESS) |=> result_valid_o)
    else $error("channel access did not produce a result");

  // Time only moves on an accepted tick
  a_time_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(time_q) |-> $past(state_q == ST_IDLE && start && action_i == ACT_TICK))
    else $error("time counter changed without a tick");

  // Offline flags only change while a check or refresh is evaluated
  a_off_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(off_q) |-> $past(state_q == ST_ACCESS || state_q == ST_SCAN))
    else $error("offline flags changed outside evaluation");

  // A refresh scan entered from idle always starts at channel zero
  a_scan_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && start && action_i == ACT_REFRESH) |=> (scan_q == '0))
    else $error("refresh scan did not start at channel zero");
`endif

endmodule

`default_nettype wire

// ===== tb/heartbeat_watch_checker.sv =====
`timescale 1ns / 100ps

// Watches command and result transfers of the heartbeat watchdog, keeps its own copy of
// the channel state, and compares every result against the oldest prediction.
module heartbeat_watch_checker
  import mchw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [2:0]  action_i,
  input  logic [3:0]  device_i,
  input  logic [31:0] value_i,
  input  logic        result_valid_i,
  input  logic [3:0]  device_echo_i,
  input  logic [1:0]  status_i,
  input  logic [15:0] offline_map_i,
  output int          fail_count_o,
  output int          pending_o
);

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [3:0]  device;
    status_e     status;
    logic [15:0] offline_map;
  } watch_status_t;

  // Predicted channel state
  logic [31:0] clock_ticks;
  logic [31:0] hb_stamp    [16];
  logic [31:0] age_limit   [16];
  logic [15:0] chan_enabled;
  logic [15:0] chan_offline;

  watch_status_t status_q[$];
  watch_status_t want;
  int            mismatches;

  // Age test for one channel; flag is stored, never just reported
  function automatic void judge_channel(int ch);
    logic [31:0] age;
    age = clock_ticks - hb_stamp[ch];
    chan_offline[ch] = (age > age_limit[ch]);
  endfunction

  // Applies one command to the predicted state and returns the status it reports
  function automatic watch_status_t apply_command(logic [2:0] act, logic [3:0] dev,
                                                  logic [31:0] val);
    watch_status_t res;
    case (act)
      ACT_TICK:    clock_ticks = clock_ticks + 32'd1;
      ACT_ENABLE: begin
        chan_enabled[dev] = 1'b1;
        age_limit[dev]    = val;
      end
      ACT_DISABLE: chan_enabled[dev] = 1'b0;
      ACT_HB_NOW:  hb_stamp[dev] = clock_ticks;
      ACT_HB_SET:  hb_stamp[dev] = val;
      ACT_CHECK: begin
        if (chan_enabled[dev]) judge_channel(dev);
      end
      ACT_REFRESH: begin
        for (int c = 0; c < 16; c++) begin
          if (chan_enabled[c]) judge_channel(c);
        end
      end
      default: ;
    endcase
    res.device = dev;
    if (!chan_enabled[dev]) begin
      res.status = STAT_DISABLED;
    end else begin
      res.status = chan_offline[dev] ? STAT_OFFLINE : STAT_ONLINE;
    end
    res.offline_map = chan_offline;
    return res;
  endfunction

  // Result check first, then prediction of a command taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_ticks  = '0;
      chan_enabled = '0;
      chan_offline = '1;
      for (int c = 0; c < 16; c++) begin
        hb_stamp[c]  = '0;
        age_limit[c] = DEFAULT_LIMIT;
      end
      status_q.delete();
      mismatches   = 0;
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (result_valid_i) begin
        if (status_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result with nothing outstanding: dev %0d status %0d map %h",
                     $realtime, device_echo_i, status_i, offline_map_i);
        end else begin
          want = status_q.pop_front();
          if (device_echo_i !== want.device || status_i !== want.status ||
              offline_map_i !== want.offline_map) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: result mismatch: dev %0d/%0d status %0d/%0d map %h/%h (exp/got)",
                       $realtime, want.device, device_echo_i, want.status, status_i,
                       want.offline_map, offline_map_i);
          end
        end
      end
      if (start_i && !busy_i) begin
        status_q.push_back(apply_command(action_i, device_i, value_i));
      end
      fail_count_o = mismatches;
      pending_o    = status_q.size();
    end
  end

endmodule

// ===== tb/multi_channel_heartbeat_watchdog_core_tb.sv =====
`timescale 1ns / 100ps

// Stimulus and verdict for the heartbeat watchdog; checking lives in the checker.
module multi_channel_heartbeat_watchdog_core_tb;
  import mchw_pkg::*;

  localparam logic [2:0] ACT_UNUSED = 3'd7;
  localparam int         STALL_LIMIT = 5000;
  localparam int         ITEMS_PER_PHASE = 400;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  action_i;
  logic [3:0]  device_i;
  logic [31:0] value_i;
  logic        result_valid_o;
  logic [3:0]  device_echo_o;
  logic [1:0]  status_o;
  logic [15:0] offline_map_o;
  int          fail_count;
  int          pending;
  int          quiet_cycles;

  multi_channel_heartbeat_watchdog_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .action_i       (action_i),
    .device_i       (device_i),
    .value_i        (value_i),
    .result_valid_o (result_valid_o),
    .device_echo_o  (device_echo_o),
    .status_o       (status_o),
    .offline_map_o  (offline_map_o)
  );

  heartbeat_watch_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .action_i       (action_i),
    .device_i       (device_i),
    .value_i        (value_i),
    .result_valid_i (result_valid_o),
    .device_echo_i  (device_echo_o),
    .status_i       (status_o),
    .offline_map_i  (offline_map_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Stall watchdog: any command or result transfer restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[multi_channel_heartbeat_watchdog_core] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One command transfer; start stays high until the block takes it
  task automatic issue_command(logic [2:0] act, logic [3:0] dev, logic [31:0] val);
    @(negedge clk_i);
    action_i <= act;
    device_i <= dev;
    value_i  <= val;
    start    <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic idle_gap(int pct);
    while ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
  endtask

  // Sender pauses until every outstanding result has come back
  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  // Random commands: ticks and small thresholds so channels cross in and out of timeout
  task automatic random_phase(int count, int pct);
    int          pick;
    int          vsel;
    logic [2:0]  act;
    logic [31:0] val;
    for (int n = 0; n < count; n++) begin
      idle_gap(pct);
      pick = $urandom_range(99);
      vsel = $urandom_range(99);
      val  = $urandom;
      if (pick < 28)      act = ACT_TICK;
      else if (pick < 38) act = ACT_ENABLE;
      else if (pick < 44) act = ACT_DISABLE;
      else if (pick < 56) act = ACT_HB_NOW;
      else if (pick < 64) act = ACT_HB_SET;
      else if (pick < 82) act = ACT_CHECK;
      else if (pick < 93) act = ACT_REFRESH;
      else                act = ACT_UNUSED;
      if (act == ACT_ENABLE) begin
        if (vsel < 55)      val = $urandom_range(6);
        else if (vsel < 65) val = '0;
        else if (vsel < 75) val = '1;
        else if (vsel < 90) val = $urandom_range(300);
      end else if (act == ACT_HB_SET) begin
        if (vsel < 60)      val = $urandom_range(700);
        else if (vsel < 70) val = '0;
        else if (vsel < 80) val = 32'hFFFF_FFFF - $urandom_range(3);
      end
      issue_command(act, 4'($urandom_range(15)), val);
    end
  endtask

  initial begin
    rst_ni   = 1'b0;
    start    = 1'b0;
    action_i = ACT_TICK;
    device_i = '0;
    value_i  = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: reset flags, threshold extremes, wrapped age, disable keeps flag
    issue_command(ACT_CHECK,   4'd0,  32'd0);          // disabled channel
    issue_command(ACT_ENABLE,  4'd0,  32'd0);          // enabled, never checked
    issue_command(ACT_CHECK,   4'd0,  '1);
    issue_command(ACT_TICK,    4'd0,  '1);
    issue_command(ACT_CHECK,   4'd0,  32'd0);          // age just over zero limit
    issue_command(ACT_HB_NOW,  4'd0,  32'd0);
    issue_command(ACT_REFRESH, 4'd0,  32'd0);
    issue_command(ACT_ENABLE,  4'd15, 32'hFFFF_FFFF);
    issue_command(ACT_HB_SET,  4'd15, 32'hFFFF_FFFF);  // heartbeat ahead, age wraps
    issue_command(ACT_CHECK,   4'd15, 32'd0);
    issue_command(ACT_ENABLE,  4'd7,  32'd1);
    issue_command(ACT_HB_SET,  4'd7,  32'd2);
    issue_command(ACT_CHECK,   4'd7,  32'd0);
    issue_command(ACT_DISABLE, 4'd7,  32'd0);
    issue_command(ACT_CHECK,   4'd7,  '1);
    issue_command(ACT_UNUSED,  4'd3,  '1);
    issue_command(ACT_TICK,    4'd9,  32'd0);
    issue_command(ACT_ENABLE,  4'd9,  32'd100);
    issue_command(ACT_HB_SET,  4'd9,  32'd0);
    issue_command(ACT_REFRESH, 4'd15, '1);
    issue_command(ACT_HB_NOW,  4'd15, 32'd0);
    issue_command(ACT_DISABLE, 4'd15, 32'd0);
    issue_command(ACT_REFRESH, 4'd0,  32'd0);
    drain_results();

    // Random phases: no idling, heavy idling, light idling, then no idling again
    random_phase(ITEMS_PER_PHASE, 0);
    drain_results();
    random_phase(ITEMS_PER_PHASE, 68);
    drain_results();
    random_phase(ITEMS_PER_PHASE, 16);
    drain_results();
    random_phase(ITEMS_PER_PHASE, 0);

    drain_results();
    repeat (40) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("[multi_channel_heartbeat_watchdog_core] OK");
    end else begin
      $display("[multi_channel_heartbeat_watchdog_core] ERROR");
    end
    $finish;
  end

endmodule
